[rtl/kfwra_pkg.sv]
// Package with shared types, constants and codes for the rate admission block.
`default_nettype none
package kfwra_pkg;
    localparam int SRC_ENTRIES_DEF = 64;
    localparam int ID_ENTRIES_DEF = 64;
    localparam int CFG_W = 32;
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CFG   = 3'd1,
        ST_NULL_ID   = 3'd2,
        ST_TIME_BACK = 3'd3,
        ST_RATE      = 3'd4,
        ST_SRC_FULL  = 3'd5,
        ST_ID_FULL   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        REG_WINDOW  = 3'd0,
        REG_GLOBAL  = 3'd1,
        REG_SOURCE  = 3'd2,
        REG_IDENT   = 3'd3,
        REG_SRC_CAP = 3'd4,
        REG_ID_CAP  = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC_SCAN,
        S_ID_SCAN,
        S_DECIDE,
        S_COMMIT,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture request, run early checks
        logic src_step;  // examine one source entry
        logic id_step;   // examine one identity entry
        logic decide;    // evaluate limits
        logic commit;    // write the admitted windows
        logic finish;    // present the result
        logic clr_idx;   // reset the scan index
    } ctrl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic early_reject;
        logic src_last;
        logic id_last;
        logic admit;
    } stat_t;
endpackage
`default_nettype wire

[rtl/keyed_fixed_window_rate_admission_top.sv]
// Top level of the keyed fixed-window rate admission block.
// A request sweeps the source table RAM and then the identity table RAM, one entry per cycle;
// an early refusal skips both sweeps and goes straight to the result.
// Throughput: one request at a time; busy stays high until the result strobe.
// The result is on the outputs for one cycle with done high; it cannot be stalled.
// Reset clears configuration to defaults, all live bits, windows and the time record.
`default_nettype none
module keyed_fixed_window_rate_admission_top #(
    parameter int SOURCE_ENTRIES   = kfwra_pkg::SRC_ENTRIES_DEF,
    parameter int IDENTITY_ENTRIES = kfwra_pkg::ID_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [63:0] now_time,
    input  wire logic [63:0] source_id,
    input  wire logic [63:0] identity_w0,
    input  wire logic [63:0] identity_w1,
    input  wire logic [63:0] identity_w2,
    input  wire logic [63:0] identity_w3,
    output logic             done,
    output logic             admitted,
    output logic [2:0]       status,
    output logic [6:0]       sources_in_use,
    output logic [6:0]       identities_in_use
);
    import kfwra_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    kfwra_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ctrl(ctrl), .stat(stat));

    kfwra_dp #(.SRC_ENTRIES(SOURCE_ENTRIES), .ID_ENTRIES(IDENTITY_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .now_time(now_time), .source_id(source_id),
        .identity_w0(identity_w0), .identity_w1(identity_w1),
        .identity_w2(identity_w2), .identity_w3(identity_w3),
        .ctrl(ctrl), .stat(stat), .done(done), .admitted(admitted),
        .status(status), .sources_in_use(sources_in_use),
        .identities_in_use(identities_in_use));
endmodule
`default_nettype wire

[rtl/kfwra_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module kfwra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/kfwra_ctrl.sv]
// Controller state machine that sequences the table sweeps.
`default_nettype none
module kfwra_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output kfwra_pkg::ctrl_t      ctrl,
    input  wire kfwra_pkg::stat_t stat
);
    import kfwra_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    ctrl.clr_idx = 1'b1;
                    state_next = S_SRC_SCAN;
                end
            end
            S_SRC_SCAN:
            begin
                if (stat.early_reject)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.src_step = 1'b1;
                    if (stat.src_last)
                    begin
                        ctrl.clr_idx = 1'b1;
                        state_next = S_ID_SCAN;
                    end
                end
            end
            S_ID_SCAN:
            begin
                ctrl.id_step = 1'b1;
                if (stat.id_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctrl.decide = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctrl.commit = stat.admit;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctrl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_SRC_SCAN)
        else $error("request not taken");
    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE)
        else $error("done did not return to idle");
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.src_step && ctrl.id_step))
        else $error("two sweeps at once");
`endif
endmodule
`default_nettype wire

[rtl/kfwra_dp.sv]
// Datapath: window state, table stores, sweeps and the admission decision.
`default_nettype none
module kfwra_dp #(
    parameter int SRC_ENTRIES = kfwra_pkg::SRC_ENTRIES_DEF,
    parameter int ID_ENTRIES  = kfwra_pkg::ID_ENTRIES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [31:0]             cfg_data,
    input  wire logic [63:0]             now_time,
    input  wire logic [63:0]             source_id,
    input  wire logic [63:0]             identity_w0,
    input  wire logic [63:0]             identity_w1,
    input  wire logic [63:0]             identity_w2,
    input  wire logic [63:0]             identity_w3,
    input  wire kfwra_pkg::ctrl_t        ctrl,
    output kfwra_pkg::stat_t             stat,
    output logic                         done,
    output logic                         admitted,
    output logic [2:0]                   status,
    output logic [6:0]                   sources_in_use,
    output logic [6:0]                   identities_in_use
);
    import kfwra_pkg::*;

    localparam int SAW = (SRC_ENTRIES > 1) ? $clog2(SRC_ENTRIES) : 1;
    localparam int IAW = (ID_ENTRIES > 1) ? $clog2(ID_ENTRIES) : 1;
    localparam int SCW = $clog2(SRC_ENTRIES + 1);
    localparam int ICW = $clog2(ID_ENTRIES + 1);
    localparam int IW  = (SAW > IAW) ? SAW : IAW;

    // configuration
    logic [31:0] win_reg, glim_reg, slim_reg, ilim_reg;
    logic [6:0]  scap_reg, icap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= 32'd60;
            glim_reg <= 32'd64;
            slim_reg <= 32'd8;
            ilim_reg <= 32'd8;
            scap_reg <= 7'd64;
            icap_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WINDOW:  win_reg  <= cfg_data;
                REG_GLOBAL:  glim_reg <= cfg_data;
                REG_SOURCE:  slim_reg <= cfg_data;
                REG_IDENT:   ilim_reg <= cfg_data;
                REG_SRC_CAP: scap_reg <= cfg_data[6:0];
                REG_ID_CAP:  icap_reg <= cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    // request capture
    logic [63:0]  now_reg, skey_reg;
    logic [255:0] ikey_reg;
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            now_reg  <= now_time;
            skey_reg <= source_id;
            ikey_reg <= {identity_w3, identity_w2, identity_w1, identity_w0};
        end
    end

    // scan index; the RAM read address runs one ahead of the entry examined
    logic [IW-1:0] idx_reg;
    logic          first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            first_reg <= 1'b0;
        end
        else if (ctrl.clr_idx)
        begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (ctrl.src_step || ctrl.id_step)
        begin
            if (first_reg)
            begin
                first_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end
    // First scan cycle only primes the RAM read.
    logic [IW-1:0] rd_idx;
    assign rd_idx = first_reg ? idx_reg : idx_reg + 1'b1;
    assign stat.src_last = !first_reg && (idx_reg == IW'(SRC_ENTRIES - 1));
    assign stat.id_last  = !first_reg && (idx_reg == IW'(ID_ENTRIES - 1));

    // stores
    logic [63:0]  s_key_rd, s_start_rd, i_start_rd;
    logic [31:0]  s_cnt_rd, i_cnt_rd;
    logic [255:0] i_key_rd;
    logic         s_new_reg, i_new_reg;
    logic [SAW-1:0] s_sel_reg;
    logic [IAW-1:0] i_sel_reg;
    logic [31:0]  s_cnt_hit_reg, i_cnt_hit_reg;
    logic         s_we, i_we;
    logic [31:0]  s_cnt_w, i_cnt_w;

    function automatic logic [31:0] bump(input logic [31:0] c);
        bump = (c == '1) ? c : c + 32'd1;
    endfunction

    assign s_we = ctrl.commit;
    assign i_we = ctrl.commit;
    assign s_cnt_w = bump(s_new_reg ? 32'd0 : s_cnt_hit_reg);
    assign i_cnt_w = bump(i_new_reg ? 32'd0 : i_cnt_hit_reg);

    // Source key and start are only written for a new entry.
    kfwra_ram #(.WIDTH(64), .DEPTH(SRC_ENTRIES)) u_skey (
        .clk(clk), .we(s_we && s_new_reg), .waddr(s_sel_reg), .wdata(skey_reg),
        .raddr(rd_idx[SAW-1:0]), .rdata(s_key_rd));
    kfwra_ram #(.WIDTH(64), .DEPTH(SRC_ENTRIES)) u_sstart (
        .clk(clk), .we(s_we && s_new_reg), .waddr(s_sel_reg), .wdata(now_reg),
        .raddr(rd_idx[SAW-1:0]), .rdata(s_start_rd));
    kfwra_ram #(.WIDTH(32), .DEPTH(SRC_ENTRIES)) u_scnt (
        .clk(clk), .we(s_we), .waddr(s_sel_reg), .wdata(s_cnt_w),
        .raddr(rd_idx[SAW-1:0]), .rdata(s_cnt_rd));
    kfwra_ram #(.WIDTH(256), .DEPTH(ID_ENTRIES)) u_ikey (
        .clk(clk), .we(i_we && i_new_reg), .waddr(i_sel_reg), .wdata(ikey_reg),
        .raddr(rd_idx[IAW-1:0]), .rdata(i_key_rd));
    kfwra_ram #(.WIDTH(64), .DEPTH(ID_ENTRIES)) u_istart (
        .clk(clk), .we(i_we && i_new_reg), .waddr(i_sel_reg), .wdata(now_reg),
        .raddr(rd_idx[IAW-1:0]), .rdata(i_start_rd));
    kfwra_ram #(.WIDTH(32), .DEPTH(ID_ENTRIES)) u_icnt (
        .clk(clk), .we(i_we), .waddr(i_sel_reg), .wdata(i_cnt_w),
        .raddr(rd_idx[IAW-1:0]), .rdata(i_cnt_rd));

    // live bits and occupancy counts
    logic [SRC_ENTRIES-1:0] s_live_reg;
    logic [ID_ENTRIES-1:0]  i_live_reg;
    logic [SCW-1:0] s_used_reg;
    logic [ICW-1:0] i_used_reg;

    // global window and time record
    logic [63:0] last_reg, gstart_reg;
    logic [31:0] gcount_reg;
    logic        known_reg, gopen_reg;

    // sweep results
    logic s_hit_reg, s_free_found_reg, i_hit_reg, i_free_found_reg;
    logic [SAW-1:0] s_hit_idx_reg, s_free_idx_reg;
    logic [IAW-1:0] i_hit_idx_reg, i_free_idx_reg;
    logic early_reg, admit_reg;
    status_t st_reg;

    function automatic logic expd(input logic [63:0] st, input logic [63:0] now,
                                  input logic [31:0] w);
        expd = (now >= st) && ((now - st) >= {32'd0, w});
    endfunction

    logic cfg_ok, null_id, back;
    assign cfg_ok = (win_reg != 0) && (glim_reg != 0) && (slim_reg != 0) &&
                    (ilim_reg != 0) && (scap_reg != 0) && (icap_reg != 0) &&
                    (slim_reg <= glim_reg) && (ilim_reg <= glim_reg);
    assign null_id = ({identity_w3, identity_w2, identity_w1, identity_w0} == '0);
    assign back = known_reg && (now_time < last_reg);

    logic [SAW-1:0] s_cur;
    logic [IAW-1:0] i_cur;
    logic s_alive, i_alive, s_exp, i_exp;
    assign s_cur = idx_reg[SAW-1:0];
    assign i_cur = idx_reg[IAW-1:0];
    assign s_exp = expd(s_start_rd, now_reg, win_reg);
    assign i_exp = expd(i_start_rd, now_reg, win_reg);
    assign s_alive = s_live_reg[s_cur] && !s_exp;
    assign i_alive = i_live_reg[i_cur] && !i_exp;

    // decision terms
    logic g_exp, g_block, s_full, i_full, lim_hit;
    logic [31:0] s_cap, i_cap;
    assign s_cap = (32'(scap_reg) < 32'(SRC_ENTRIES)) ? 32'(scap_reg) : 32'(SRC_ENTRIES);
    assign i_cap = (32'(icap_reg) < 32'(ID_ENTRIES)) ? 32'(icap_reg) : 32'(ID_ENTRIES);
    assign g_exp = expd(gstart_reg, now_reg, win_reg);
    assign g_block = gopen_reg && !g_exp && (gcount_reg >= glim_reg);
    assign s_full = !s_hit_reg && ((32'(s_used_reg) >= s_cap) || !s_free_found_reg);
    assign i_full = !i_hit_reg && ((32'(i_used_reg) >= i_cap) || !i_free_found_reg);
    assign lim_hit = (s_hit_reg && s_cnt_hit_reg >= slim_reg) ||
                     (i_hit_reg && i_cnt_hit_reg >= ilim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_live_reg <= '0;
            i_live_reg <= '0;
            s_used_reg <= '0;
            i_used_reg <= '0;
            last_reg   <= '0;
            gstart_reg <= '0;
            gcount_reg <= '0;
            known_reg  <= 1'b0;
            gopen_reg  <= 1'b0;
            early_reg  <= 1'b0;
            admit_reg  <= 1'b0;
            st_reg     <= ST_OK;
            s_hit_reg  <= 1'b0;
            i_hit_reg  <= 1'b0;
            s_free_found_reg <= 1'b0;
            i_free_found_reg <= 1'b0;
            s_hit_idx_reg <= '0;
            s_free_idx_reg <= '0;
            i_hit_idx_reg <= '0;
            i_free_idx_reg <= '0;
            s_cnt_hit_reg <= '0;
            i_cnt_hit_reg <= '0;
            s_new_reg <= 1'b0;
            i_new_reg <= 1'b0;
            s_sel_reg <= '0;
            i_sel_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                admit_reg <= 1'b0;
                s_hit_reg <= 1'b0;
                i_hit_reg <= 1'b0;
                s_free_found_reg <= 1'b0;
                i_free_found_reg <= 1'b0;
                early_reg <= 1'b1;
                if (!cfg_ok)
                begin
                    st_reg <= ST_BAD_CFG;
                end
                else if (null_id)
                begin
                    st_reg <= ST_NULL_ID;
                end
                else if (back)
                begin
                    st_reg <= ST_TIME_BACK;
                end
                else
                begin
                    early_reg <= 1'b0;
                    st_reg    <= ST_OK;
                    known_reg <= 1'b1;
                    last_reg  <= now_time;
                end
            end
            if (ctrl.src_step && !first_reg)
            begin
                if (s_live_reg[s_cur] && s_exp)
                begin
                    s_live_reg[s_cur] <= 1'b0;
                    s_used_reg <= s_used_reg - 1'b1;
                end
                if (s_alive)
                begin
                    if (!s_hit_reg && s_key_rd == skey_reg)
                    begin
                        s_hit_reg <= 1'b1;
                        s_hit_idx_reg <= s_cur;
                        s_cnt_hit_reg <= s_cnt_rd;
                    end
                end
                else if (!s_free_found_reg)
                begin
                    s_free_found_reg <= 1'b1;
                    s_free_idx_reg <= s_cur;
                end
            end
            if (ctrl.id_step && !first_reg)
            begin
                if (i_live_reg[i_cur] && i_exp)
                begin
                    i_live_reg[i_cur] <= 1'b0;
                    i_used_reg <= i_used_reg - 1'b1;
                end
                if (i_alive)
                begin
                    if (!i_hit_reg && i_key_rd == ikey_reg)
                    begin
                        i_hit_reg <= 1'b1;
                        i_hit_idx_reg <= i_cur;
                        i_cnt_hit_reg <= i_cnt_rd;
                    end
                end
                else if (!i_free_found_reg)
                begin
                    i_free_found_reg <= 1'b1;
                    i_free_idx_reg <= i_cur;
                end
            end
            if (ctrl.decide)
            begin
                if (g_block)
                begin
                    st_reg <= ST_RATE;
                end
                else if (s_full)
                begin
                    st_reg <= ST_SRC_FULL;
                end
                else if (i_full)
                begin
                    st_reg <= ST_ID_FULL;
                end
                else if (lim_hit)
                begin
                    st_reg <= ST_RATE;
                end
                else
                begin
                    admit_reg <= 1'b1;
                end
                s_new_reg <= !s_hit_reg;
                i_new_reg <= !i_hit_reg;
                s_sel_reg <= s_hit_reg ? s_hit_idx_reg : s_free_idx_reg;
                i_sel_reg <= i_hit_reg ? i_hit_idx_reg : i_free_idx_reg;
            end
            if (ctrl.commit)
            begin
                if (!gopen_reg || g_exp)
                begin
                    gopen_reg  <= 1'b1;
                    gstart_reg <= now_reg;
                    gcount_reg <= 32'd1;
                end
                else
                begin
                    gcount_reg <= bump(gcount_reg);
                end
                if (s_new_reg)
                begin
                    s_live_reg[s_sel_reg] <= 1'b1;
                    s_used_reg <= s_used_reg + 1'b1;
                end
                if (i_new_reg)
                begin
                    i_live_reg[i_sel_reg] <= 1'b1;
                    i_used_reg <= i_used_reg + 1'b1;
                end
            end
        end
    end

    assign stat.early_reject = early_reg;
    assign stat.admit = admit_reg;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
            admitted <= 1'b0;
            status <= '0;
            sources_in_use <= '0;
            identities_in_use <= '0;
        end
        else
        begin
            done <= ctrl.finish;
            if (ctrl.finish)
            begin
                admitted <= admit_reg;
                status <= st_reg;
                sources_in_use <= 7'(s_used_reg);
                identities_in_use <= 7'(i_used_reg);
            end
        end
    end

`ifndef SYNTHESIS
    a_src_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(s_used_reg) == 32'($countones(s_live_reg)))
        else $error("source occupancy out of step");
    a_id_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(i_used_reg) == 32'($countones(i_live_reg)))
        else $error("identity occupancy out of step");
    a_admit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (admitted == (status == ST_OK)))
        else $error("admit flag disagrees with status");
`endif
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the keyed fixed-window rate admission block.
module tb_top;
    import kfwra_pkg::*;

    localparam int NSRC = 64;
    localparam int NID = 64;

    typedef struct packed {
        logic [63:0] now_time;
        logic [63:0] source_id;
        logic [255:0] ident;
    } request_t;

    typedef struct packed {
        logic admitted;
        logic [2:0] status;
        logic [6:0] src_used;
        logic [6:0] id_used;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic [63:0] now_time = '0;
    logic [63:0] source_id = '0;
    logic [63:0] identity_w0 = '0;
    logic [63:0] identity_w1 = '0;
    logic [63:0] identity_w2 = '0;
    logic [63:0] identity_w3 = '0;
    logic busy, done, admitted;
    logic [2:0] status;
    logic [6:0] sources_in_use, identities_in_use;

    keyed_fixed_window_rate_admission_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .now_time(now_time), .source_id(source_id),
        .identity_w0(identity_w0), .identity_w1(identity_w1),
        .identity_w2(identity_w2), .identity_w3(identity_w3),
        .done(done), .admitted(admitted), .status(status),
        .sources_in_use(sources_in_use), .identities_in_use(identities_in_use)
    );

    always #10 clk = ~clk;

    // Predictor state.
    logic [31:0] win_len, glob_lim, src_lim, id_lim;
    logic [6:0] src_cap, id_cap;
    logic [63:0] prev_time;
    logic seen_any;
    logic [63:0] glob_begin;
    logic [31:0] glob_cnt;
    logic glob_open;
    logic [63:0] src_key [NSRC];
    logic [63:0] src_begin [NSRC];
    logic [31:0] src_cnt [NSRC];
    logic src_on [NSRC];
    logic [255:0] id_key [NID];
    logic [63:0] id_begin [NID];
    logic [31:0] id_cnt [NID];
    logic id_on [NID];

    request_t pending_requests[$];
    verdict_t expected_verdicts[$];
    int mismatches = 0;
    int gap = 0;
    logic stim_done = 1'b0;

    // Configuration writes requested by the stimulus process, applied by the driver.
    logic cfg_req = 1'b0;
    logic [2:0] cfg_req_idx;
    logic [31:0] cfg_req_val;

    function automatic logic window_over(logic [63:0] b, logic [63:0] t);
        return t >= b && (t - b) >= {32'd0, win_len};
    endfunction

    function automatic logic [6:0] live_sources();
        int n = 0;
        for (int i = 0; i < NSRC; i++) n += src_on[i];
        return n[6:0];
    endfunction

    function automatic logic [6:0] live_identities();
        int n = 0;
        for (int i = 0; i < NID; i++) n += id_on[i];
        return n[6:0];
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return c == 32'hFFFF_FFFF ? c : c + 32'd1;
    endfunction

    function automatic verdict_t admit_request(request_t r);
        verdict_t v;
        int s_hit = -1, i_hit = -1, s_free = -1, i_free = -1;
        int s_lim_cap, i_lim_cap;
        logic cfg_ok;
        v = '0;
        cfg_ok = win_len != 0 && glob_lim != 0 && src_lim != 0 && id_lim != 0 &&
                 src_cap != 0 && id_cap != 0 && src_lim <= glob_lim && id_lim <= glob_lim;
        v.status = ST_OK;
        if (!cfg_ok) v.status = ST_BAD_CFG;
        else if (r.ident == '0) v.status = ST_NULL_ID;
        else if (seen_any && r.now_time < prev_time) v.status = ST_TIME_BACK;
        if (v.status == ST_OK) begin
            seen_any = 1'b1;
            prev_time = r.now_time;
            for (int i = 0; i < NSRC; i++)
                if (src_on[i] && window_over(src_begin[i], r.now_time)) src_on[i] = 1'b0;
            for (int i = 0; i < NID; i++)
                if (id_on[i] && window_over(id_begin[i], r.now_time)) id_on[i] = 1'b0;
            if (glob_open && !window_over(glob_begin, r.now_time) && glob_cnt >= glob_lim)
                v.status = ST_RATE;
        end
        if (v.status == ST_OK) begin
            for (int i = 0; i < NSRC; i++)
                if (src_on[i]) begin
                    if (s_hit < 0 && src_key[i] == r.source_id) s_hit = i;
                end else if (s_free < 0) s_free = i;
            for (int i = 0; i < NID; i++)
                if (id_on[i]) begin
                    if (i_hit < 0 && id_key[i] == r.ident) i_hit = i;
                end else if (i_free < 0) i_free = i;
            s_lim_cap = src_cap < NSRC ? src_cap : NSRC;
            i_lim_cap = id_cap < NID ? id_cap : NID;
            if (s_hit < 0 && (live_sources() >= s_lim_cap || s_free < 0))
                v.status = ST_SRC_FULL;
            else if (i_hit < 0 && (live_identities() >= i_lim_cap || i_free < 0))
                v.status = ST_ID_FULL;
            else if ((s_hit >= 0 && src_cnt[s_hit] >= src_lim) ||
                     (i_hit >= 0 && id_cnt[i_hit] >= id_lim))
                v.status = ST_RATE;
        end
        if (v.status == ST_OK) begin
            v.admitted = 1'b1;
            if (!glob_open || window_over(glob_begin, r.now_time)) begin
                glob_open = 1'b1;
                glob_begin = r.now_time;
                glob_cnt = 0;
            end
            glob_cnt = sat_inc(glob_cnt);
            if (s_hit < 0) begin
                s_hit = s_free;
                src_on[s_hit] = 1'b1;
                src_key[s_hit] = r.source_id;
                src_begin[s_hit] = r.now_time;
                src_cnt[s_hit] = 0;
            end
            src_cnt[s_hit] = sat_inc(src_cnt[s_hit]);
            if (i_hit < 0) begin
                i_hit = i_free;
                id_on[i_hit] = 1'b1;
                id_key[i_hit] = r.ident;
                id_begin[i_hit] = r.now_time;
                id_cnt[i_hit] = 0;
            end
            id_cnt[i_hit] = sat_inc(id_cnt[i_hit]);
        end
        v.src_used = live_sources();
        v.id_used = live_identities();
        return v;
    endfunction

    // Driver: one request at a time, with a random gap before each.
    always @(posedge clk) begin
        if (rst_n) begin
            cfg_we <= cfg_req;
            cfg_index <= cfg_req_idx;
            cfg_data <= cfg_req_val;
            if (start && !busy) begin
                start <= 1'b0;
                gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            end else if (!start && !busy && gap > 0) begin
                gap <= gap - 1;
            end else if (!start && !busy && pending_requests.size() > 0 && !cfg_req) begin
                request_t r;
                verdict_t pv;
                r = pending_requests[0];
                pending_requests.delete(0);
                pv = admit_request(r);
                expected_verdicts = {expected_verdicts, pv};
                now_time <= r.now_time;
                source_id <= r.source_id;
                {identity_w3, identity_w2, identity_w1, identity_w0} <= r.ident;
                start <= 1'b1;
            end
        end
    end

    // Monitor.
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $time);
            end else begin
                verdict_t e;
                e = expected_verdicts[0];
                expected_verdicts.delete(0);
                if (e != {admitted, status, sources_in_use, identities_in_use}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp adm=%0d st=%0d src=%0d id=%0d got %0d %0d %0d %0d",
                            e.admitted, e.status, e.src_used, e.id_used,
                            admitted, status, sources_in_use, identities_in_use);
                end
            end
        end
    end

    // Requests sit in the queue until the block is idle; this waits for all of them.
    task automatic drain();
        while (pending_requests.size() > 0 || expected_verdicts.size() > 0 || start || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_req <= 1'b1;
        cfg_req_idx <= idx;
        cfg_req_val <= val;
        @(posedge clk);
        cfg_req <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WINDOW: win_len = val;
            REG_GLOBAL: glob_lim = val;
            REG_SOURCE: src_lim = val;
            REG_IDENT: id_lim = val;
            REG_SRC_CAP: src_cap = val[6:0];
            default: id_cap = val[6:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_all(logic [31:0] w, logic [31:0] g, logic [31:0] s, logic [31:0] i,
                           logic [6:0] sc, logic [6:0] ic);
        write_reg(REG_WINDOW, w);
        write_reg(REG_GLOBAL, g);
        write_reg(REG_SOURCE, s);
        write_reg(REG_IDENT, i);
        write_reg(REG_SRC_CAP, {25'd0, sc});
        write_reg(REG_ID_CAP, {25'd0, ic});
    endtask

    function automatic logic [255:0] rand_wide();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    logic [63:0] clock_now = 64'd100;

    // Mostly realistic traffic: small pools of keys, slowly advancing time.
    task automatic add_traffic(int n, int nkeys);
        request_t r;
        logic [63:0] src_pool [8];
        logic [255:0] id_pool [8];
        for (int k = 0; k < 8; k++) begin
            src_pool[k] = rand64();
            id_pool[k] = rand_wide();
        end
        for (int k = 0; k < n; k++) begin
            int sel;
            sel = $urandom_range(0, 19);
            if (sel == 0 && clock_now > 5) clock_now = clock_now - $urandom_range(1, 5);
            else if (sel < 12) clock_now = clock_now + $urandom_range(0, 3);
            r.now_time = clock_now;
            r.source_id = $urandom_range(0, 4) == 0 ? rand64() : src_pool[$urandom_range(0, nkeys - 1)];
            case ($urandom_range(0, 9))
                0: r.ident = '0;
                1: r.ident = rand_wide();
                default: r.ident = id_pool[$urandom_range(0, nkeys - 1)];
            endcase
            pending_requests = {pending_requests, r};
        end
    endtask

    initial begin
        request_t r;
        win_len = 60; glob_lim = 64; src_lim = 8; id_lim = 8; src_cap = 64; id_cap = 64;
        seen_any = 0; prev_time = 0; glob_begin = 0; glob_cnt = 0; glob_open = 0;
        for (int i = 0; i < NSRC; i++) src_on[i] = 0;
        for (int i = 0; i < NID; i++) id_on[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: null identity, first time, per-key limits, time backwards, extremes.
        r = '{64'd0, 64'd0, 256'd0};
        pending_requests = {pending_requests, r};
        r = '{64'd0, 64'd0, 256'd1};
        pending_requests = {pending_requests, r};
        for (int k = 0; k < 9; k++) begin
            r = '{64'd10, 64'd5, {1'b1, 255'd0}};
            pending_requests = {pending_requests, r};
        end
        r = '{64'd9, 64'd5, 256'd7};
        pending_requests = {pending_requests, r};
        r = '{64'd70, 64'hFFFF_FFFF_FFFF_FFFF, {256{1'b1}}};
        pending_requests = {pending_requests, r};
        r = '{64'hFFFF_FFFF_FFFF_FFF0, 64'd1, 256'd3};
        pending_requests = {pending_requests, r};
        drain();

        // Tiny capacities and limits: table-full and rate statuses.
        set_all(32'd5, 32'd3, 32'd2, 32'd2, 7'd1, 7'd1);
        for (int k = 0; k < 6; k++) begin
            r = '{64'hFFFF_FFFF_FFFF_FFF0 + k, 64'(k % 2), 256'(k % 3 + 1)};
            pending_requests = {pending_requests, r};
        end
        drain();

        // Invalid settings: each must report a bad configuration.
        set_all(32'd0, 32'd1, 32'd1, 32'd1, 7'd1, 7'd1);
        r = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 256'd1};
        pending_requests = {pending_requests, r};
        drain();
        set_all(32'd1, 32'd1, 32'd2, 32'd1, 7'd0, 7'd127);
        pending_requests = {pending_requests, r};
        drain();

        // Random phases with varied settings.
        for (int ph = 0; ph < 13; ph++) begin
            case (ph % 4)
                0: set_all(32'($urandom_range(1, 20)), 32'($urandom_range(4, 40)),
                           32'($urandom_range(1, 4)), 32'($urandom_range(1, 4)),
                           7'($urandom_range(1, 10)), 7'($urandom_range(1, 10)));
                1: set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           7'd127, 7'd127);
                2: set_all(32'($urandom_range(2, 30)), 32'd64, 32'd8, 32'd8, 7'd64, 7'd64);
                default: set_all($urandom, $urandom, $urandom, $urandom,
                                 7'($urandom), 7'($urandom));
            endcase
            if (ph == 7) clock_now = 64'hFFFF_FFFF_FFFF_FE00;
            add_traffic(100, ph % 2 ? 8 : 3);
            drain();
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (mismatches == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
